/* hdl/bba_pkg.sv */
package bba_pkg;

  localparam int POOL_BLOCKS = 64;
  localparam int BLOCK_BYTES = 16;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int IDX_W = $clog2(POOL_BLOCKS);
  localparam int CNT_W = $clog2(POOL_BLOCKS + 1);
  localparam int REQ_W = 11;
  localparam int OFF_W = 10;
  localparam int STS_W = 3;

  localparam logic [STS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STS_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STS_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STS_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STS_W-1:0] ST_NULL     = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] used_idx;
    logic             used_set;
    logic             used_clr;
    logic [IDX_W-1:0] vld_idx;
    logic             vld_set;
    logic             vld_clr;
  } bba_map_cmd_t;

endpackage

/* hdl/bba_len_ram.sv */
module bba_len_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 7
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bba_bitmap.sv */
// used-block bitmap plus per-block valid bits for the length table
module bba_bitmap
  import bba_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bba_map_cmd_t cmd,
  output logic         used_bit,
  output logic         vld_bit
);

  logic [POOL_BLOCKS-1:0] used_r;
  logic [POOL_BLOCKS-1:0] used_nxt;
  logic [POOL_BLOCKS-1:0] vld_r;
  logic [POOL_BLOCKS-1:0] vld_nxt;

  always_comb begin
    used_nxt = used_r;
    vld_nxt  = vld_r;
    if (cmd.used_set) begin
      used_nxt[cmd.used_idx] = 1'b1;
    end else if (cmd.used_clr) begin
      used_nxt[cmd.used_idx] = 1'b0;
    end
    if (cmd.vld_set) begin
      vld_nxt[cmd.vld_idx] = 1'b1;
    end else if (cmd.vld_clr) begin
      vld_nxt[cmd.vld_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      vld_r  <= '0;
    end else begin
      used_r <= used_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign used_bit = used_r[cmd.used_idx];
  assign vld_bit  = vld_r[cmd.vld_idx];

endmodule

/* hdl/bitmap_block_allocator.sv */
// Channel | Dir | Ports                                                        | Handshake
// in_     | in  | opcode, request_bytes, free_offset, pointer_is_null          | valid/stall
// out_    | out | status, start_offset                                         | valid/stall
//
// Allocate: accept, then a scan of up to POOL_BLOCKS bitmap bits (one bitmap bit per cycle),
//   then a mark step per block of the run; zero size and oversize finish at accept.
// Free: accept (length RAM read), length check, then a clear step per block.
// The result sits in an output register; in_stall stays high until it is taken.
// Synchronous reset clears the bitmap and the length valid bits at once, no sweep.
// out_stall only holds the result register; the sequencer is idle meanwhile.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [OFF_W-1:0] in_free_offset,
  input  logic             in_pointer_is_null,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [STS_W-1:0] out_status,
  output logic [OFF_W-1:0] out_start_offset
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_RDLEN = 3'd3;
  localparam logic [2:0] S_CLR   = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_BLOCKS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STS_W-1:0] out_status_r, out_status_nxt;
  logic [OFF_W-1:0] out_offset_r, out_offset_nxt;

  logic               in_acc;
  logic [REQ_W:0]     need_full;
  logic [OFF_W-1:0]   blk_full;
  logic               blk_oor;
  logic [CNT_W-1:0]   run_inc;
  logic [CNT_W:0]     first_w;
  logic [OFF_W+IDX_W-1:0] off_w;
  logic [CNT_W-1:0]   len;

  bba_map_cmd_t     map_cmd;
  logic             used_bit;
  logic             vld_bit;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [CNT_W-1:0] ram_rd_data;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign in_acc    = in_valid && !in_stall;

  assign need_full = ({1'b0, in_request_bytes} + (REQ_W+1)'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
  assign blk_full  = in_free_offset >> BLOCK_SHIFT;
  assign blk_oor   = {1'b0, blk_full} >= (OFF_W+1)'(POOL_BLOCKS);
  assign run_inc   = cnt_r + 1'b1;
  assign first_w   = (CNT_W+1)'(ptr_r) + (CNT_W+1)'(1) - (CNT_W+1)'(need_r);
  assign off_w     = (OFF_W+IDX_W)'(first_r) << BLOCK_SHIFT;
  assign len       = vld_bit ? ram_rd_data : '0;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    first_nxt      = first_r;
    need_nxt       = need_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;

    map_cmd          = '0;
    map_cmd.used_idx = ptr_r;
    map_cmd.vld_idx  = ptr_r;
    ram_wr_en        = 1'b0;
    ram_rd_en        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_offset_nxt = '0;
          if (in_opcode == OP_ALLOC) begin
            if (in_request_bytes == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_ZERO;
            end else if (need_full > (REQ_W+1)'(POOL_BLOCKS)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOSPACE;
            end else begin
              need_nxt  = need_full[CNT_W-1:0];
              ptr_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            if (in_pointer_is_null) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NULL;
            end else if (blk_oor) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOTALLOC;
            end else begin
              ram_rd_en = 1'b1;
              ptr_nxt   = blk_full[IDX_W-1:0];
              state_nxt = S_RDLEN;
            end
          end
        end
      end
      S_SCAN: begin
        if (used_bit) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = run_inc;
        end
        if (!used_bit && run_inc == need_r) begin
          first_nxt       = first_w[IDX_W-1:0];
          ram_wr_en       = 1'b1;
          map_cmd.vld_idx = first_w[IDX_W-1:0];
          map_cmd.vld_set = 1'b1;
          end_nxt         = ptr_r;
          ptr_nxt         = first_w[IDX_W-1:0];
          state_nxt       = S_MARK;
        end else if (ptr_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOSPACE;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_MARK: begin
        map_cmd.used_set = 1'b1;
        if (ptr_r == end_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_offset_nxt = off_w[OFF_W-1:0];
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_RDLEN: begin
        if (len == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTALLOC;
          state_nxt      = S_IDLE;
        end else begin
          map_cmd.vld_clr = 1'b1;
          cnt_nxt         = len;
          state_nxt       = S_CLR;
        end
      end
      S_CLR: begin
        map_cmd.used_clr = 1'b1;
        if (cnt_r == CNT_W'(1) || ptr_r == LAST_IDX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    end_r        <= end_nxt;
    first_r      <= first_nxt;
    need_r       <= need_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  bba_bitmap u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (map_cmd),
    .used_bit (used_bit),
    .vld_bit  (vld_bit)
  );

  bba_len_ram #(
    .DEPTH (POOL_BLOCKS),
    .WIDTH (CNT_W)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (first_w[IDX_W-1:0]),
    .wr_data (need_r),
    .rd_en   (ram_rd_en),
    .rd_addr (blk_full[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_start_offset = out_offset_r;

  a_result_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result pending while sequencer busy");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE) || out_valid_r)
    else $error("accepted transaction dropped");

  a_mark_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> ptr_r <= end_r)
    else $error("mark pointer past run end");

  a_clr_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> cnt_r != '0)
    else $error("clear pass with zero length");

  a_scan_need_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> need_r != '0 && cnt_r < need_r)
    else $error("scan run count out of range");

endmodule

/* dv/bitmap_block_allocator_tb.sv */
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int LEN_W          = 7;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [OFF_W-1:0] start_offset;
  } alloc_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_opcode;
  logic [REQ_W-1:0] in_request_bytes;
  logic [OFF_W-1:0] in_free_offset;
  logic             in_pointer_is_null;
  logic             out_valid;
  logic             out_stall;
  logic [STS_W-1:0] out_status;
  logic [OFF_W-1:0] out_start_offset;

  // shadow of the allocator state, updated at each accepted request
  logic [POOL_BLOCKS-1:0] pool_used;
  logic [LEN_W-1:0]       pool_run_len [POOL_BLOCKS];
  alloc_result_t          expected_results [$];

  int err_count     = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token    = 0;
  int hold_len      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  bitmap_block_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_request_bytes   (in_request_bytes),
    .in_free_offset     (in_free_offset),
    .in_pointer_is_null (in_pointer_is_null),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_start_offset   (out_start_offset)
  );

  always #1 clk = ~clk;

  function automatic void predict_request(input logic op, input logic [REQ_W-1:0] bytes,
                                          input logic [OFF_W-1:0] off, input logic nul);
    alloc_result_t res;
    int            need;
    int            run;
    int            first;
    int            blk;
    int            len;
    int            i;
    res.status       = ST_OK;
    res.start_offset = '0;
    if (op == OP_ALLOC) begin
      if (bytes == '0) begin
        res.status = ST_ZERO;
      end else begin
        need       = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        first      = -1;
        run        = 0;
        res.status = ST_NOSPACE;
        if (need <= POOL_BLOCKS) begin
          for (i = 0; i < POOL_BLOCKS && first < 0; i++) begin
            if (pool_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) first = i + 1 - need;
            end
          end
        end
        if (first >= 0) begin
          for (i = first; i < first + need; i++) pool_used[i] = 1'b1;
          pool_run_len[first] = LEN_W'(need);
          res.status          = ST_OK;
          res.start_offset    = OFF_W'(first * BLOCK_BYTES);
        end
      end
    end else if (nul) begin
      res.status = ST_NULL;
    end else begin
      blk = int'(off) / BLOCK_BYTES;
      len = (blk < POOL_BLOCKS) ? int'(pool_run_len[blk]) : 0;
      if (len == 0) begin
        res.status = ST_NOTALLOC;
      end else begin
        for (i = blk; i < blk + len && i < POOL_BLOCKS; i++) pool_used[i] = 1'b0;
        pool_run_len[blk] = '0;
      end
    end
    expected_results.push_back(res);
  endfunction

  task automatic send_request(input logic op, input int bytes, input int off, input logic nul);
    bit gap;
    gap = ($urandom_range(0, 99) < send_idle_pct);
    while (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap = ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_request_bytes   <= REQ_W'(bytes);
    in_free_offset     <= OFF_W'(off);
    in_pointer_is_null <= nul;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, REQ_W'(bytes), OFF_W'(off), nul);
  endtask

  task automatic send_random_request();
    int used;
    int pick;
    int sel;
    int bytes;
    int blk;
    int alloc_share;
    int live [$];
    int i;
    used = $countones(pool_used);
    alloc_share = (used > 48) ? 25 : (used < 16) ? 70 : 45;
    pick = $urandom_range(0, 99);
    for (i = 0; i < POOL_BLOCKS; i++) if (pool_run_len[i] != '0) live.push_back(i);
    if (pick < 10) begin
      send_request(1'($urandom_range(0, 1)), $urandom_range(0, 2047), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
    end else if (pick < 10 + alloc_share) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: bytes = $urandom_range(0, 2047);
        1: bytes = 0;
        8: bytes = $urandom_range(129, 1024);
        9: bytes = BLOCK_BYTES * $urandom_range(1, 8);
        default: bytes = $urandom_range(1, 128);
      endcase
      send_request(OP_ALLOC, bytes, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
    end else if (live.size() == 0) begin
      send_request(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023),
                   1'($urandom_range(0, 1)));
    end else begin
      blk = live[$urandom_range(0, live.size() - 1)];
      sel = $urandom_range(0, 19);
      // occasional broken frees: null, inside a run, or a stale start
      if (sel == 0) begin
        send_request(OP_FREE, $urandom_range(0, 2047), blk * BLOCK_BYTES, 1'b1);
      end else if (sel == 1 && pool_run_len[blk] > 1) begin
        send_request(OP_FREE, $urandom_range(0, 2047),
                     (blk + $urandom_range(1, pool_run_len[blk] - 1)) * BLOCK_BYTES, 1'b0);
      end else begin
        send_request(OP_FREE, $urandom_range(0, 2047),
                     blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1), 1'b0);
        if (sel == 2) begin
          send_request(OP_FREE, $urandom_range(0, 2047), blk * BLOCK_BYTES, 1'b0);
        end
      end
    end
  endtask

  task automatic test_alloc_basics();
    send_request(OP_ALLOC, 0, 0, 1'b0);
    send_request(OP_ALLOC, 1, 0, 1'b0);
    send_request(OP_ALLOC, 16, 0, 1'b0);
    send_request(OP_ALLOC, 17, 0, 1'b0);
    send_request(OP_ALLOC, 2047, 1023, 1'b1);
    send_request(OP_ALLOC, 1025, 0, 1'b0);
    send_request(OP_ALLOC, 1024, 0, 1'b0);
  endtask

  task automatic test_free_cases();
    send_request(OP_FREE, 0, 0, 1'b1);
    send_request(OP_FREE, 0, 48, 1'b0);
    send_request(OP_FREE, 0, 16, 1'b0);
    send_request(OP_FREE, 0, 16, 1'b0);
    send_request(OP_ALLOC, 16, 1023, 1'b1);
    send_request(OP_FREE, 0, 41, 1'b0);
    send_request(OP_FREE, 2047, 0, 1'b0);
    send_request(OP_FREE, 0, 16, 1'b0);
  endtask

  task automatic test_full_pool();
    send_request(OP_ALLOC, 1024, 1023, 1'b1);
    send_request(OP_ALLOC, 1, 0, 1'b0);
    send_request(OP_FREE, 0, 1023, 1'b0);
    send_request(OP_FREE, 2047, 15, 1'b0);
    send_request(OP_ALLOC, 1008, 0, 1'b0);
    send_request(OP_ALLOC, 16, 0, 1'b0);
    send_request(OP_FREE, 0, 1008, 1'b0);
    send_request(OP_FREE, 0, 0, 1'b0);
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_random_request();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len   <= HOLDOFF_CYCLES;
    hold_token <= hold_token + 1;
    repeat (12) send_random_request();
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected transaction: status %0d start_offset %0d",
                   out_status, out_start_offset);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_start_offset !== want.start_offset) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: status exp %0d got %0d, start_offset exp %0d got %0d",
                     want.status, out_status, want.start_offset, out_start_offset);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_block_allocator_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pool_used = '0;
    for (int i = 0; i < POOL_BLOCKS; i++) pool_run_len[i] = '0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_opcode          <= OP_ALLOC;
    in_request_bytes   <= '0;
    in_free_offset     <= '0;
    in_pointer_is_null <= 1'b0;
    out_stall          <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alloc_basics();
    test_free_cases();
    test_full_pool();
    test_random(200, 0, 0);
    test_random(180, 50, 0);
    test_backpressure();
    test_random(180, 0, 50);
    test_random(190, 27, 27);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("bitmap_block_allocator_tb: clean");
    end else begin
      $display("bitmap_block_allocator_tb: errors");
    end
    $finish;
  end

endmodule
